>>> rtl/sac_pkg.sv
package sac_pkg;

  // fixed field widths
  localparam int ADDR_W       = 64;
  localparam int OP_W         = 2;
  localparam int HITS_W       = 2;
  localparam int CNT_W        = 32;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // block offset never exceeds this
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_CAP = BLOCK_BITS_W'(32);

  // register reset values
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = SET_BITS_W'(1);
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = BLOCK_BITS_W'(1);
  localparam logic [WAYS_W-1:0]       WAYS_RST       = WAYS_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } reg_idx_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_LOOKUP = 1'b1
  } bk_state_t;

endpackage

>>> rtl/sac_if.sv
interface sac_acc_if;
  import sac_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink   (input valid, input op, input address, output ready);
endinterface

interface sac_res_if;
  import sac_pkg::*;

  logic              valid;
  logic              ready;
  logic [HITS_W-1:0] hits_added;
  logic              missed;
  logic              evicted;
  logic [CNT_W-1:0]  total_hits;
  logic [CNT_W-1:0]  total_misses;
  logic [CNT_W-1:0]  total_evictions;

  modport source (output valid, output hits_added, output missed, output evicted,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink   (input valid, input hits_added, input missed, input evicted,
                  input total_hits, input total_misses, input total_evictions,
                  output ready);
endinterface

>>> rtl/sac_front.sv
module sac_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int ADDR_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  sac_acc_if.sink                          acc,
  input  logic [sac_pkg::SET_BITS_W-1:0]   set_bits,
  input  logic [sac_pkg::BLOCK_BITS_W-1:0] block_bits,
  output logic                             q_valid,
  input  logic                             q_pop,
  output logic [MAX_SET_BITS-1:0]          q_set,
  output logic [ADDR_BITS-3:0]             q_tag,
  output logic                             q_double
);
  import sac_pkg::*;

  localparam int TAG_W  = ADDR_BITS - 2;
  localparam int QDEPTH = 2;  // power of two, pointers wrap
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [SET_BITS_W-1:0] S_CAP =
    (MAX_SET_BITS > 7) ? SET_BITS_W'(7) : SET_BITS_W'(MAX_SET_BITS);

  logic [SET_BITS_W-1:0]   s_eff;
  logic [BLOCK_BITS_W-1:0] b_eff;
  logic [BLOCK_BITS_W:0]   sb;
  logic [ADDR_BITS-1:0]    a;
  logic [ADDR_BITS-1:0]    shifted;
  logic [ADDR_BITS-1:0]    tag_full;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] new_set;
  logic [TAG_W-1:0]        new_tag;
  logic                    new_double;
  logic                    push;

  logic [MAX_SET_BITS-1:0] ent_set    [QDEPTH];
  logic [TAG_W-1:0]        ent_tag    [QDEPTH];
  logic                    ent_double [QDEPTH];
  logic [PTR_W-1:0]        wptr;
  logic [PTR_W-1:0]        rptr;
  logic [QCNT_W-1:0]       count;

  // split address into set index and tag with clamped geometry
  always_comb begin
    if (set_bits == '0) s_eff = SET_BITS_W'(1);
    else if (set_bits > S_CAP) s_eff = S_CAP;
    else s_eff = set_bits;
    if (block_bits == '0) b_eff = BLOCK_BITS_W'(1);
    else if (block_bits > BLOCK_CAP) b_eff = BLOCK_CAP;
    else b_eff = block_bits;
    sb         = {1'b0, b_eff} + (BLOCK_BITS_W + 1)'(s_eff);
    a          = acc.address[ADDR_BITS-1:0];
    shifted    = a >> b_eff;
    tag_full   = a >> sb;
    set_mask   = ~({MAX_SET_BITS{1'b1}} << s_eff);
    new_set    = shifted[MAX_SET_BITS-1:0] & set_mask;
    new_tag    = tag_full[TAG_W-1:0];
    new_double = (acc.op == OP_MODIFY);
  end

  assign acc.ready = (count != QCNT_W'(QDEPTH));
  assign push      = acc.valid && acc.ready;
  assign q_valid   = (count != '0);
  assign q_set     = ent_set[rptr];
  assign q_tag     = ent_tag[rptr];
  assign q_double  = ent_double[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_set[wptr]    <= new_set;
      ent_tag[wptr]    <= new_tag;
      ent_double[wptr] <= new_double;
    end
  end

endmodule

>>> rtl/sac_back.sv
module sac_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sac_pkg::WAYS_W-1:0] ways_in_use,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [MAX_SET_BITS-1:0]    q_set,
  input  logic [ADDR_BITS-3:0]       q_tag,
  input  logic                       q_double,
  sac_res_if.source                  res
);
  import sac_pkg::*;

  localparam int SET_COUNT = 1 << MAX_SET_BITS;
  localparam int TAG_W    = ADDR_BITS - 2;
  localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
  localparam logic [WAYS_W-1:0] W_CAP =
    (MAX_WAYS > 15) ? WAYS_W'(15) : WAYS_W'(MAX_WAYS);

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } line_t;
  typedef line_t [MAX_WAYS-1:0] row_t;

  function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] v);
    return (v < AGE_MAX) ? v + 1'b1 : v;
  endfunction

  row_t                    mem [SET_COUNT];
  logic [SET_COUNT-1:0]    row_valid;
  row_t                    rd_row;
  logic                    rd_ok;
  logic [MAX_SET_BITS-1:0] cur_set;
  logic [TAG_W-1:0]        cur_tag;
  logic                    cur_double;

  bk_state_t state, state_next;
  logic      rd_en;
  logic      finish;

  logic [WAYS_W-1:0]  w_eff;
  row_t               cur_row;
  row_t               new_row;
  logic [MAX_WAYS-1:0] in_use;
  logic               hit;
  logic [AGE_W-1:0]   hit_way;
  logic [AGE_W-1:0]   hit_age;
  logic               has_free;
  logic [AGE_W-1:0]   free_way;
  logic [AGE_W-1:0]   vic_way;
  logic [AGE_W-1:0]   vic_age;
  logic               evict;

  logic [HITS_W-1:0]  hits_add;
  logic [CNT_W:0]     hit_sum;
  logic [CNT_W-1:0]   hit_total, hit_total_next;
  logic [CNT_W-1:0]   miss_total, miss_total_next;
  logic [CNT_W-1:0]   evict_total, evict_total_next;

  logic               res_valid;
  logic [HITS_W-1:0]  res_hits;
  logic               res_missed;
  logic               res_evicted;

  // sequencer: read the set row, then compare and write it back
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    finish     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        if (!res_valid || res.ready) begin
          finish     = 1'b1;
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  // row memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row     <= mem[q_set];
      rd_ok      <= row_valid[q_set];
      cur_set    <= q_set;
      cur_tag    <= q_tag;
      cur_double <= q_double;
    end
    if (finish) mem[cur_set] <= new_row;
  end

  // a row never written reads as all invalid, age zero
  always_ff @(posedge clk) begin
    if (rst) row_valid <= '0;
    else if (finish) row_valid[cur_set] <= 1'b1;
  end

  // lookup, victim choice and recency update
  always_comb begin
    if (ways_in_use == '0) w_eff = WAYS_W'(1);
    else if (ways_in_use > W_CAP) w_eff = W_CAP;
    else w_eff = ways_in_use;
    cur_row  = rd_ok ? rd_row : '0;
    hit      = 1'b0;
    hit_way  = '0;
    hit_age  = '0;
    has_free = 1'b0;
    free_way = '0;
    vic_way  = '0;
    vic_age  = cur_row[0].age;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (i < int'(w_eff));
      if (!hit && in_use[i] && cur_row[i].valid && cur_row[i].tag == cur_tag) begin
        hit     = 1'b1;
        hit_way = AGE_W'(i);
        hit_age = cur_row[i].age;
      end
      if (!has_free && in_use[i] && !cur_row[i].valid) begin
        has_free = 1'b1;
        free_way = AGE_W'(i);
      end
    end
    // oldest line wins, lowest way on a tie
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && cur_row[i].age > vic_age) begin
        vic_way = AGE_W'(i);
        vic_age = cur_row[i].age;
      end
    end
    evict   = !hit && !has_free;
    new_row = cur_row;
    if (hit) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (in_use[j] && AGE_W'(j) != hit_way && cur_row[j].valid &&
            cur_row[j].age < hit_age)
          new_row[j].age = age_up(cur_row[j].age);
      end
      new_row[hit_way].age = '0;
    end else if (has_free) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (in_use[j] && cur_row[j].valid) new_row[j].age = age_up(cur_row[j].age);
      end
      new_row[free_way].valid = 1'b1;
      new_row[free_way].age   = '0;
      new_row[free_way].tag   = cur_tag;
    end else begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (in_use[j] && AGE_W'(j) != vic_way && cur_row[j].age < vic_age)
          new_row[j].age = age_up(cur_row[j].age);
      end
      new_row[vic_way].age = '0;
      new_row[vic_way].tag = cur_tag;
    end
  end

  // saturating totals; the second access of a modify always hits
  always_comb begin
    hits_add       = {1'b0, hit} + {1'b0, cur_double};
    hit_sum        = {1'b0, hit_total} + (CNT_W + 1)'(hits_add);
    hit_total_next = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_total_next  = miss_total;
    evict_total_next = evict_total;
    if (!hit && miss_total != '1) miss_total_next = miss_total + 1'b1;
    if (evict && evict_total != '1) evict_total_next = evict_total + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (finish) begin
        hit_total   <= hit_total_next;
        miss_total  <= miss_total_next;
        evict_total <= evict_total_next;
        res_valid   <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_hits    <= hits_add;
      res_missed  <= !hit;
      res_evicted <= evict;
    end
  end

  assign res.valid           = res_valid;
  assign res.hits_added      = res_hits;
  assign res.missed          = res_missed;
  assign res.evicted         = res_evicted;
  assign res.total_hits      = hit_total;
  assign res.total_misses    = miss_total;
  assign res.total_evictions = evict_total;

`ifndef SYNTHESIS
  a_read_then_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE && q_valid) |=> (state == BK_LOOKUP))
    else $error("row read not followed by lookup");

  a_hit_or_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_missed || res_hits != '0))
    else $error("first access neither hit nor missed");

  a_evict_needs_miss: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_evicted) |-> (res_missed && res_hits != HITS_W'(3)))
    else $error("eviction reported without a miss");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    finish |=> row_valid[$past(cur_set)])
    else $error("written row not marked valid");
`endif

endmodule

>>> rtl/set_assoc_cache_lru_model_unit.sv
// channel  dir  payload                                           handshake
// acc      in   op, address                                       valid / ready
// res      out  hits_added, missed, evicted, total_hits,          valid / ready
//               total_misses, total_evictions
// apb      in   set_bits @0x0, block_bits @0x4, ways_in_use @0x8  psel / penable, pready = 1
//
// in the back end a transaction first reads the set row from the single-port row
// memory, then compares tags, picks a victim and writes it back
// the front takes one transaction per cycle while its 2-entry queue is not full, so
// a burst of up to two is absorbed while the back end is busy or the result is stalled
// a stalled result holds the back end in its lookup cycle; the front keeps filling
// reset clears control state and the per-row valid bits; no clearing pass is run
module set_assoc_cache_lru_model_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  sac_acc_if.sink                     acc,
  sac_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sac_pkg::PADDR_W-1:0] paddr,
  input  logic [sac_pkg::PDATA_W-1:0] pwdata,
  output logic [sac_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sac_pkg::*;

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]       ways_in_use;
  reg_idx_t                reg_idx;
  logic                    cfg_wr;

  // front to back queue head
  logic                    q_valid;
  logic                    q_pop;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [ADDR_BITS-3:0]    q_tag;
  logic                    q_double;

  // word address selects the register, byte offset ignored
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RST;
      block_bits  <= BLOCK_BITS_RST;
      ways_in_use <= WAYS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SET_BITS:   set_bits    <= pwdata[SET_BITS_W-1:0];
        REG_BLOCK_BITS: block_bits  <= pwdata[BLOCK_BITS_W-1:0];
        REG_WAYS:       ways_in_use <= pwdata[WAYS_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_SET_BITS:   prdata = PDATA_W'(set_bits);
      REG_BLOCK_BITS: prdata = PDATA_W'(block_bits);
      REG_WAYS:       prdata = PDATA_W'(ways_in_use);
      default:        prdata = '0;
    endcase
  end

  // front: address split by the configured geometry, 2-entry queue
  sac_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .set_bits   (set_bits),
    .block_bits (block_bits),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_set      (q_set),
    .q_tag      (q_tag),
    .q_double   (q_double)
  );

  // back: row read, tag compare, lru update, running totals
  sac_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .ways_in_use (ways_in_use),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_set       (q_set),
    .q_tag       (q_tag),
    .q_double    (q_double),
    .res         (res)
  );

endmodule
